// File: rtl/plw_pkg.sv
// Package for the PLL latch word generator: state type, status codes,
// latch select codes, prescaler band edges and register indexes.
// No dependencies.
`default_nettype none

package plw_pkg;

    // Divider geometry: 16-bit dividend (frequency), 8-bit divisor (step)
    localparam int DIV_W = 16;
    localparam int DSR_W = 8;
    localparam int CNT_W = $clog2(DIV_W);

    // Status codes carried on every result
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOCFG   = 2'd1;
    localparam logic [1:0] ST_N_SMALL = 2'd2;
    localparam logic [1:0] ST_B_LOW   = 2'd3;

    // Latch select codes, low two bits of each word
    localparam logic [1:0] SEL_R    = 2'h0;
    localparam logic [1:0] SEL_N    = 2'h1;
    localparam logic [1:0] SEL_FUNC = 2'h2;
    localparam logic [1:0] SEL_INIT = 2'h3;

    // Lower edges of the prescaler bands (inclusive)
    localparam logic [DIV_W-1:0] MIN_N8  = 16'd56;
    localparam logic [DIV_W-1:0] MIN_N16 = 16'd240;
    localparam logic [DIV_W-1:0] MIN_N32 = 16'd992;
    localparam logic [DIV_W-1:0] MIN_N64 = 16'd4032;

    // Prescaler codes
    localparam logic [1:0] PS_8  = 2'd0;
    localparam logic [1:0] PS_16 = 2'd1;
    localparam logic [1:0] PS_32 = 2'd2;
    localparam logic [1:0] PS_64 = 2'd3;

    // Configuration register indexes (byte address / 4)
    localparam logic [2:0] REG_REF_FREQ = 3'd0;
    localparam logic [2:0] REG_STEP     = 3'd1;
    localparam logic [2:0] REG_CP_GAIN  = 3'd2;
    localparam logic [2:0] REG_R_OPT    = 3'd3;
    localparam logic [2:0] REG_FUNC_OPT = 3'd4;

    // Request sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_NOCFG,
        S_DIV_R,
        S_DIV_N,
        S_CHECK,
        S_WORD_F,
        S_WORD_R,
        S_WORD_N
    } t_state;

endpackage

`default_nettype wire

// File: rtl/pll_latch_word_generator.sv
// Top level of the PLL latch word generator: APB register file, request
// sequencer, counter check and latch word assembly. Depends on plw_pkg, plw_div.
`default_nettype none

// A request is taken when start is high and busy is low. A start command
// (i_cmd 0) before any initialize gives one result with status 1 in the cycle
// right after the accepting edge. Otherwise the block computes R = ref/step,
// then N = freq/step, in two passes through one shared bit-serial divider,
// checks the prescaler band and the A/B split, and then presents three
// results on consecutive cycles (function or init latch, R latch, N latch),
// each marked by o_valid for one cycle; o_last is set on the third. The
// receiver cannot stall: each result is seen in its cycle only. A full
// request keeps busy high from the accepting edge until its last result
// has been presented. On a status of 2 or 3 the stored counters keep their
// earlier values and the words are built from those.
// Configuration registers should be written only while busy is low.
module pll_latch_word_generator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_cmd,
    input  wire logic [15:0] i_freq_mhz,
    // results
    output logic             o_valid,
    output logic [23:0]      o_latch_word,
    output logic [1:0]       o_status,
    output logic             o_last,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import plw_pkg::*;

    // Configuration registers
    logic [9:0]  r_ref_freq;
    logic [7:0]  r_step;
    logic        r_cp_gain;
    logic [6:0]  r_r_opt;
    logic [19:0] r_func_opt;

    // Stored PLL setting
    logic        r_configured;
    logic [13:0] r_rcnt;
    logic [12:0] r_bcnt;
    logic [5:0]  r_acnt;
    logic [1:0]  r_pcode;

    // Request context
    t_state      r_state, n_state;
    logic        r_cmd;
    logic [15:0] r_freq;
    logic [13:0] r_rquot;
    logic [15:0] r_nquot;
    logic [1:0]  r_status;

    // Divider interface
    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic [DSR_W-1:0] div_divisor;
    logic             div_done;
    logic [DIV_W-1:0] div_quot;

    logic        accept;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    // Check results
    logic [1:0]  n_code;
    logic [5:0]  n_acnt;
    logic [12:0] n_bcnt;
    logic [1:0]  n_status;

    assign accept  = start && !busy;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_freq <= 10'd10;
            r_step     <= 8'd1;
            r_cp_gain  <= 1'b0;
            r_r_opt    <= '0;
            r_func_opt <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_REF_FREQ: r_ref_freq <= pwdata[9:0];
                REG_STEP:     r_step     <= pwdata[7:0];
                REG_CP_GAIN:  r_cp_gain  <= pwdata[0];
                REG_R_OPT:    r_r_opt    <= pwdata[6:0];
                REG_FUNC_OPT: r_func_opt <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (cfg_idx)
            REG_REF_FREQ: prdata = {22'd0, r_ref_freq};
            REG_STEP:     prdata = {24'd0, r_step};
            REG_CP_GAIN:  prdata = {31'd0, r_cp_gain};
            REG_R_OPT:    prdata = {25'd0, r_r_opt};
            REG_FUNC_OPT: prdata = {12'd0, r_func_opt};
            default:      prdata = '0;
        endcase
    end

    // Shared divider; a zero step divides by one
    assign div_divisor = (r_step == '0) ? DSR_W'(1) : r_step;

    plw_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    // Prescaler band, A/B split and validity of the new setting
    always_comb begin
        if (r_nquot < MIN_N16) begin
            n_code = PS_8;
            n_acnt = {3'd0, r_nquot[2:0]};
            n_bcnt = 13'(r_nquot >> 3);
        end else if (r_nquot < MIN_N32) begin
            n_code = PS_16;
            n_acnt = {2'd0, r_nquot[3:0]};
            n_bcnt = 13'(r_nquot >> 4);
        end else if (r_nquot < MIN_N64) begin
            n_code = PS_32;
            n_acnt = {1'b0, r_nquot[4:0]};
            n_bcnt = 13'(r_nquot >> 5);
        end else begin
            n_code = PS_64;
            n_acnt = r_nquot[5:0];
            n_bcnt = 13'(r_nquot >> 6);
        end

        if (r_nquot < MIN_N8) begin
            n_status = ST_N_SMALL;
        end else if (n_bcnt < {7'd0, n_acnt}) begin
            n_status = ST_B_LOW;
        end else begin
            n_status = ST_OK;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (!i_cmd && !r_configured) ? S_NOCFG : S_DIV_R;
                end
            end
            S_NOCFG:  n_state = S_IDLE;
            S_DIV_R:  if (div_done) n_state = S_DIV_N;
            S_DIV_N:  if (div_done) n_state = S_CHECK;
            S_CHECK:  n_state = S_WORD_F;
            S_WORD_F: n_state = S_WORD_R;
            S_WORD_R: n_state = S_WORD_N;
            S_WORD_N: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Outputs and divider kicks
    always_comb begin
        busy         = 1'b1;
        o_valid      = 1'b0;
        o_last       = 1'b0;
        o_status     = r_status;
        o_latch_word = '0;
        div_start    = 1'b0;
        div_dividend = r_freq;
        unique case (r_state)
            S_IDLE: begin
                busy         = 1'b0;
                div_start    = accept && (i_cmd || r_configured);
                div_dividend = {6'd0, r_ref_freq};
            end
            S_NOCFG: begin
                o_valid  = 1'b1;
                o_last   = 1'b1;
                o_status = ST_NOCFG;
            end
            S_DIV_R: begin
                div_start = div_done;
            end
            S_DIV_N, S_CHECK: ;
            S_WORD_F: begin
                o_valid      = 1'b1;
                o_latch_word = {r_pcode, r_func_opt, (r_cmd ? SEL_INIT : SEL_FUNC)};
            end
            S_WORD_R: begin
                o_valid      = 1'b1;
                o_latch_word = {1'b0, r_r_opt, r_rcnt, SEL_R};
            end
            S_WORD_N: begin
                o_valid      = 1'b1;
                o_last       = 1'b1;
                o_latch_word = {2'd0, r_cp_gain, r_bcnt, r_acnt, SEL_N};
            end
            default: ;
        endcase
    end

    // State and stored setting
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_configured <= 1'b0;
            r_rcnt       <= '0;
            r_bcnt       <= '0;
            r_acnt       <= '0;
            r_pcode      <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CHECK) begin
                if (r_cmd) r_configured <= 1'b1;
                if (n_status == ST_OK) begin
                    r_rcnt  <= r_rquot;
                    r_bcnt  <= n_bcnt;
                    r_acnt  <= n_acnt;
                    r_pcode <= n_code;
                end
            end
        end
    end

    // Request context capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= i_cmd;
            r_freq <= i_freq_mhz;
        end
        if (r_state == S_DIV_R && div_done) r_rquot <= div_quot[13:0];
        if (r_state == S_DIV_N && div_done) r_nquot <= div_quot;
        if (r_state == S_CHECK) r_status <= n_status;
    end

    // Checks
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result presented while idle");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !busy)
        else $error("still busy after final result");

    a_nocfg_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_NOCFG) |-> o_last)
        else $error("not-configured status on a non-final result");

    a_word_f_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=> (o_valid && $stable(o_status)))
        else $error("transaction sequence broken");

endmodule

`default_nettype wire

// File: rtl/plw_div.sv
// Bit-serial restoring divider: one quotient bit per clock.
// Depends on plw_pkg.
`default_nettype none

module plw_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [plw_pkg::DIV_W-1:0] i_dividend,
    input  wire logic [plw_pkg::DSR_W-1:0] i_divisor,
    output logic                           o_done,
    output logic [plw_pkg::DIV_W-1:0]      o_quotient
);
    import plw_pkg::*;

    logic             r_run;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DSR_W-1:0] r_rem;
    logic [DIV_W-1:0] r_qsr;   // dividend bits shift out on top, quotient bits in below
    logic [DSR_W-1:0] r_dsr;

    logic [DSR_W:0]   trial;
    logic [DSR_W:0]   diff;
    logic             ge;
    logic [DSR_W-1:0] n_rem;

    // One restoring step: bring in the next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_qsr[DIV_W-1]};
        diff  = trial - {1'b0, r_dsr};
        ge    = (trial >= {1'b0, r_dsr});
        n_rem = ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_qsr <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_run) begin
            r_rem <= n_rem;
            r_qsr <= {r_qsr[DIV_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_qsr;

endmodule

`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for the PLL latch word generator.
// Depends on plw_pkg and pll_latch_word_generator; predicts every latch word
// in a built-in model of the counter programming and checks each result.
`timescale 1ns / 100ps

module testbench;
    import plw_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_MAX  = 10;

    // One expected result transaction
    typedef struct packed {
        logic [23:0] word;
        logic [1:0]  status;
        logic        last;
    } t_latch_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cmd = 1'b0;
    logic [15:0] i_freq_mhz = '0;
    logic        o_valid;
    logic [23:0] o_latch_word;
    logic [1:0]  o_status;
    logic        o_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Register copies
    logic [9:0]  cfg_ref_freq = 10'd10;
    logic [7:0]  cfg_step = 8'd1;
    logic        cfg_cp_gain = 1'b0;
    logic [6:0]  cfg_r_opts = '0;
    logic [19:0] cfg_func_opts = '0;

    // Programmed synthesizer state
    logic        pll_configured = 1'b0;
    logic [13:0] pll_r_count = '0;
    logic [12:0] pll_b_count = '0;
    logic [5:0]  pll_a_count = '0;
    logic [1:0]  pll_ps_code = PS_8;

    t_latch_result pending_words[$];
    int error_count = 0;
    int cycle_count = 0;

    pll_latch_word_generator dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_freq_mhz   (i_freq_mhz),
        .o_valid      (o_valid),
        .o_latch_word (o_latch_word),
        .o_status     (o_status),
        .o_last       (o_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench NOT OK");
            $finish;
        end
    end

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        error_count++;
        if (error_count <= REPORT_MAX)
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
    endtask

    // Compare each result transaction with the oldest expected one
    always @(posedge i_clk) begin : check_results
        t_latch_result want;
        if (i_rst_n && o_valid) begin
            if (pending_words.size() == 0) begin
                note_mismatch("unexpected result", '0, {5'd0, o_latch_word, o_status, o_last});
            end else begin
                want = pending_words.pop_front();
                if (o_latch_word !== want.word)
                    note_mismatch("latch_word", want.word, o_latch_word);
                if (o_status !== want.status)
                    note_mismatch("status", want.status, o_status);
                if (o_last !== want.last)
                    note_mismatch("last", want.last, o_last);
            end
        end
    end

    function automatic logic [31:0] config_value(input logic [2:0] idx);
        case (idx)
            REG_REF_FREQ: return {22'd0, cfg_ref_freq};
            REG_STEP:     return {24'd0, cfg_step};
            REG_CP_GAIN:  return {31'd0, cfg_cp_gain};
            REG_R_OPT:    return {25'd0, cfg_r_opts};
            REG_FUNC_OPT: return {12'd0, cfg_func_opts};
            default:      return '0;
        endcase
    endfunction

    // Expected words for one request; updates the programmed state
    task automatic predict_latch_words(input logic cmd, input logic [15:0] freq);
        logic [7:0]  div;
        logic [15:0] n_div;
        logic [15:0] r_div;
        logic [15:0] a_cnt;
        logic [15:0] b_cnt;
        logic [1:0]  code;
        logic [1:0]  st;
        logic [1:0]  sel;
        int          shift;
        if (!cmd && !pll_configured) begin
            pending_words.push_back('{word: '0, status: ST_NOCFG, last: 1'b1});
            return;
        end
        div = (cfg_step == 0) ? 8'd1 : cfg_step;
        n_div = freq / div;
        r_div = {6'd0, cfg_ref_freq} / div;
        st = ST_OK;
        if (n_div < MIN_N8) begin
            st = ST_N_SMALL;
        end else begin
            if (n_div < MIN_N16) begin
                code = PS_8;  shift = 3;
            end else if (n_div < MIN_N32) begin
                code = PS_16; shift = 4;
            end else if (n_div < MIN_N64) begin
                code = PS_32; shift = 5;
            end else begin
                code = PS_64; shift = 6;
            end
            a_cnt = n_div & ((16'd1 << shift) - 16'd1);
            b_cnt = n_div >> shift;
            if (b_cnt < a_cnt) begin
                st = ST_B_LOW;
            end else begin
                pll_r_count = r_div[13:0];
                pll_b_count = b_cnt[12:0];
                pll_a_count = a_cnt[5:0];
                pll_ps_code = code;
            end
        end
        sel = cmd ? SEL_INIT : SEL_FUNC;
        if (cmd)
            pll_configured = 1'b1;
        pending_words.push_back('{word: {pll_ps_code, cfg_func_opts, sel},
                                  status: st, last: 1'b0});
        pending_words.push_back('{word: {1'b0, cfg_r_opts, pll_r_count, SEL_R},
                                  status: st, last: 1'b0});
        pending_words.push_back('{word: {2'b00, cfg_cp_gain, pll_b_count, pll_a_count, SEL_N},
                                  status: st, last: 1'b1});
    endtask

    // One APB transaction; a write also updates the register copies
    task automatic apb_transfer(input bit is_write, input logic [2:0] idx,
                                input logic [31:0] wdata);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = is_write;
        paddr = {idx, 2'b00};
        pwdata = wdata;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (is_write) begin
            case (idx)
                REG_REF_FREQ: cfg_ref_freq = wdata[9:0];
                REG_STEP:     cfg_step = wdata[7:0];
                REG_CP_GAIN:  cfg_cp_gain = wdata[0];
                REG_R_OPT:    cfg_r_opts = wdata[6:0];
                REG_FUNC_OPT: cfg_func_opts = wdata[19:0];
                default: ;
            endcase
        end else if (prdata !== config_value(idx)) begin
            note_mismatch("register readback", config_value(idx), prdata);
        end
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Write and read back a register
    task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
        apb_transfer(1'b1, idx, value);
        apb_transfer(1'b0, idx, '0);
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || busy !== 1'b0)
            @(negedge i_clk);
    endtask

    task automatic program_all(input logic [9:0] ref_mhz, input logic [7:0] step_mhz,
                               input logic cp, input logic [6:0] ropt,
                               input logic [19:0] fopt);
        wait_drained();
        write_register(REG_REF_FREQ, {22'd0, ref_mhz});
        write_register(REG_STEP, {24'd0, step_mhz});
        write_register(REG_CP_GAIN, {31'd0, cp});
        write_register(REG_R_OPT, {25'd0, ropt});
        write_register(REG_FUNC_OPT, {12'd0, fopt});
    endtask

    // Mostly no gap, sometimes a short one, rarely a long one; no gap when quiet
    task automatic idle_gap(input bit quiet);
        int pick;
        int gap;
        pick = $urandom_range(0, 99);
        gap = 0;
        if (!quiet) begin
            if (pick >= 92)
                gap = $urandom_range(8, 40);
            else if (pick >= 60)
                gap = $urandom_range(1, 3);
        end
        repeat (gap) @(negedge i_clk);
    endtask

    // Offer one request, hold it until busy is low at the accepting edge
    task automatic send_request(input logic cmd, input logic [15:0] freq, input bit quiet);
        @(negedge i_clk);
        start = 1'b1;
        i_cmd = cmd;
        i_freq_mhz = freq;
        do @(posedge i_clk); while (busy !== 1'b0);
        predict_latch_words(cmd, freq);
        @(negedge i_clk);
        start = 1'b0;
        idle_gap(quiet);
    endtask

    // Frequency aimed at a random prescaler band, or fully random
    function automatic logic [15:0] pick_freq();
        int div;
        int n_max;
        int lo;
        int hi;
        int band;
        int f;
        div = (cfg_step == 0) ? 1 : cfg_step;
        n_max = 65535 / div;
        band = $urandom_range(0, 6);
        case (band)
            0: begin lo = 0;    hi = 55;    end
            1: begin lo = 56;   hi = 239;   end
            2: begin lo = 240;  hi = 991;   end
            3: begin lo = 992;  hi = 4031;  end
            4: begin lo = 4032; hi = 65535; end
            default: return 16'($urandom_range(0, 65535));
        endcase
        if (lo > n_max)
            return 16'($urandom_range(0, 65535));
        if (hi > n_max)
            hi = n_max;
        f = $urandom_range(lo, hi) * div + $urandom_range(0, div - 1);
        return (f > 65535) ? 16'hFFFF : 16'(f);
    endfunction

    // Starts before any init only report the missing configuration
    task automatic test_before_init();
        send_request(1'b0, 16'h0000, 1'b0);
        send_request(1'b0, 16'hFFFF, 1'b0);
    endtask

    // An init with too small N still marks the synthesizer configured
    task automatic test_init_error();
        send_request(1'b1, 16'd10, 1'b0);
        send_request(1'b0, 16'd55, 1'b0);
    endtask

    // Prescaler band edges with step 1, maximum options
    task automatic test_band_edges();
        int edges[$] = '{56, 63, 239, 240, 255, 991, 992, 1023, 4031, 4032, 65535};
        program_all(10'd1023, 8'd1, 1'b1, 7'h7F, 20'hFFFFF);
        foreach (edges[k])
            send_request(1'b0, 16'(edges[k]), 1'b0);
        send_request(1'b1, 16'd4095, 1'b0);
    endtask

    // Largest and zero channel step
    task automatic test_step_extremes();
        program_all(10'd1, 8'd255, 1'b0, 7'h00, 20'h00000);
        send_request(1'b0, 16'hFFFF, 1'b0);
        send_request(1'b0, 16'd14024, 1'b0);
        send_request(1'b0, 16'd14025, 1'b0);
        program_all(10'd777, 8'd0, 1'b1, 7'h55, 20'hA5A5A);
        send_request(1'b0, 16'd100, 1'b0);
        send_request(1'b1, 16'd3, 1'b0);
    endtask

    // Random requests over several register settings
    task automatic test_random_phases();
        int  per_phase;
        bit  quiet;
        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0: program_all(10'd1, 8'd1, 1'b0, 7'h00, 20'h00000);
                1: program_all(10'd1023, 8'd255, 1'b1, 7'h7F, 20'hFFFFF);
                2: program_all(10'($urandom_range(1, 1023)), 8'd0, 1'b1,
                               7'($urandom), 20'($urandom));
                default: program_all(10'($urandom_range(1, 1023)),
                                     8'($urandom_range(1, 40)), 1'($urandom),
                                     7'($urandom), 20'($urandom));
            endcase
            quiet = (phase == 4);
            per_phase = 46;
            for (int k = 0; k < per_phase; k++) begin
                // hold off until the block is fully drained once mid-phase
                if (phase == 3 && k == per_phase / 2)
                    wait_drained();
                send_request(($urandom_range(0, 9) == 0), pick_freq(), quiet);
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_before_init();
        test_init_error();
        test_band_edges();
        test_step_extremes();
        test_random_phases();

        wait_drained();
        repeat (50) @(negedge i_clk);
        if (pending_words.size() != 0)
            note_mismatch("missing results", '0, pending_words.size());

        if (error_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
